>>> src/iep_pkg.sv
// ----------------------------------------------------------------------------
// iep_pkg
// Shared types and character constants for the IPv4 endpoint parser.
// ----------------------------------------------------------------------------
package iep_pkg;

    localparam logic [7:0]  CHAR_ZERO  = 8'h30;
    localparam logic [7:0]  CHAR_NINE  = 8'h39;
    localparam logic [7:0]  CHAR_COLON = 8'h3A;
    localparam logic [7:0]  CHAR_DOT   = 8'h2E;
    localparam logic [7:0]  CHAR_TAB   = 8'h09;
    localparam logic [7:0]  CHAR_CR    = 8'h0D;
    localparam logic [7:0]  CHAR_SPACE = 8'h20;

    localparam logic [19:0] OCTET_MAX  = 20'd255;
    localparam logic [19:0] PORT_MAX   = 20'd65535;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_FORMAT = 2'd1,
        STATUS_OCTET  = 2'd2,
        STATUS_PORT   = 2'd3
    } status_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  octet_a;
        logic [7:0]  octet_b;
        logic [7:0]  octet_c;
        logic [7:0]  octet_d;
        logic [15:0] port_number;
    } iep_result_t;

endpackage

>>> src/iep_parse.sv
// ----------------------------------------------------------------------------
// iep_parse
// Parse state for one endpoint string: flags, counters, decimal accumulator
// and octet store. Produces the result for the step that ends the text.
// ----------------------------------------------------------------------------
module iep_parse
    import iep_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  ch,
    input  logic        last,
    output iep_result_t result
);

    typedef enum logic [1:0] {
        ADDR_OK     = 2'd0,
        ADDR_DOTTED = 2'd1,
        ADDR_FOURTH = 2'd2
    } addr_fault_t;

    typedef struct packed {
        logic        nonempty;
        logic        bad_char;
        logic        overflow;
        logic [15:0] value;
    } field_t;

    localparam field_t FIELD_CLEAR = '{nonempty: 1'b0, bad_char: 1'b0,
                                       overflow: 1'b0, value: 16'd0};

    function automatic logic field_faulty(input field_t f);
        field_faulty = !f.nonempty || f.bad_char || f.overflow;
    endfunction

    function automatic field_t take_char(input field_t f, input logic [7:0] c,
                                         input logic port_phase);
        logic [19:0] limit;
        logic [19:0] v;
        logic [7:0]  digit;
        field_t      r;
        r          = f;
        r.nonempty = 1'b1;
        limit      = port_phase ? PORT_MAX : OCTET_MAX;
        digit      = c - CHAR_ZERO;
        v          = ({4'd0, f.value} << 3) + ({4'd0, f.value} << 1) + {12'd0, digit};
        if (c < CHAR_ZERO || c > CHAR_NINE)
        begin
            r.bad_char = 1'b1;
        end
        else if (!f.bad_char && !f.overflow)
        begin
            if (v > limit)
                r.overflow = 1'b1;
            else
                r.value = v[15:0];
        end
        take_char = r;
    endfunction

    logic        port_phase_reg, port_phase_next;
    logic [2:0]  dot_count_reg, dot_count_next;
    logic [1:0]  colon_count_reg, colon_count_next;
    logic        first_pending_reg;
    field_t      field_reg, field_next;
    logic        format_fault_reg, format_fault_next;
    addr_fault_t addr_fault_reg, addr_fault_next;
    logic [7:0]  octet_reg [4];
    logic [7:0]  octet_next [4];

    logic        is_space;
    logic        is_colon;
    logic        is_dot;
    status_t     status;

    always_comb
    begin
        is_space = (ch >= CHAR_TAB && ch <= CHAR_CR) || ch == CHAR_SPACE;
        is_colon = ch == CHAR_COLON;
        is_dot   = ch == CHAR_DOT && !port_phase_reg;

        port_phase_next   = port_phase_reg;
        dot_count_next    = dot_count_reg;
        colon_count_next  = colon_count_reg;
        field_next        = field_reg;
        addr_fault_next   = addr_fault_reg;
        format_fault_next = format_fault_reg || is_space
                            || (is_colon && (first_pending_reg || last));
        for (int i = 0; i < 4; i++)
            octet_next[i] = octet_reg[i];

        if (is_colon)
        begin
            if (colon_count_reg != 2'd2)
                colon_count_next = colon_count_reg + 2'd1;
            if (colon_count_reg == 2'd0)
            begin
                // first colon closes the fourth octet
                if (dot_count_reg == 3'd3)
                begin
                    octet_next[3] = field_reg.value[7:0];
                    if (field_faulty(field_reg) && addr_fault_reg == ADDR_OK)
                        addr_fault_next = ADDR_FOURTH;
                end
                field_next      = FIELD_CLEAR;
                port_phase_next = 1'b1;
            end
            else
            begin
                field_next = take_char(field_reg, ch, port_phase_reg);
            end
        end
        else if (is_dot)
        begin
            if (dot_count_reg < 3'd3)
            begin
                octet_next[dot_count_reg[1:0]] = field_reg.value[7:0];
                if (field_faulty(field_reg) && addr_fault_reg == ADDR_OK)
                    addr_fault_next = ADDR_DOTTED;
            end
            if (dot_count_reg != 3'd7)
                dot_count_next = dot_count_reg + 3'd1;
            field_next = FIELD_CLEAR;
        end
        else
        begin
            field_next = take_char(field_reg, ch, port_phase_reg);
        end

        priority if (format_fault_next || colon_count_next != 2'd1)
            status = STATUS_FORMAT;
        else if (addr_fault_next == ADDR_DOTTED)
            status = STATUS_OCTET;
        else if (dot_count_next != 3'd3)
            status = STATUS_FORMAT;
        else if (addr_fault_next == ADDR_FOURTH)
            status = STATUS_OCTET;
        else if (field_faulty(field_next) || field_next.value == 16'd0)
            status = STATUS_PORT;
        else
            status = STATUS_OK;

        result.status      = status;
        result.octet_a     = (status == STATUS_OK) ? octet_next[0] : 8'd0;
        result.octet_b     = (status == STATUS_OK) ? octet_next[1] : 8'd0;
        result.octet_c     = (status == STATUS_OK) ? octet_next[2] : 8'd0;
        result.octet_d     = (status == STATUS_OK) ? octet_next[3] : 8'd0;
        result.port_number = (status == STATUS_OK) ? field_next.value : 16'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_phase_reg    <= 1'b0;
            dot_count_reg     <= 3'd0;
            colon_count_reg   <= 2'd0;
            first_pending_reg <= 1'b1;
            field_reg         <= FIELD_CLEAR;
            format_fault_reg  <= 1'b0;
            addr_fault_reg    <= ADDR_OK;
        end
        else if (step)
        begin
            if (last)
            begin
                // string done: back to the start state
                port_phase_reg    <= 1'b0;
                dot_count_reg     <= 3'd0;
                colon_count_reg   <= 2'd0;
                first_pending_reg <= 1'b1;
                field_reg         <= FIELD_CLEAR;
                format_fault_reg  <= 1'b0;
                addr_fault_reg    <= ADDR_OK;
            end
            else
            begin
                port_phase_reg    <= port_phase_next;
                dot_count_reg     <= dot_count_next;
                colon_count_reg   <= colon_count_next;
                first_pending_reg <= 1'b0;
                field_reg         <= field_next;
                format_fault_reg  <= format_fault_next;
                addr_fault_reg    <= addr_fault_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            for (int i = 0; i < 4; i++)
                octet_reg[i] <= octet_next[i];
        end
    end

endmodule

>>> src/ipv4_endpoint_parser_core.sv
// Path: a character transfer ending the text reaches the result outputs through
//   the input register, then the result register.
// Throughput: one character per cycle while the input register is not stalled.
// Stall on the result side holds the input register only when it holds the
//   final character of a text.
// Reset: asynchronous, active low; clears the parse state and both valids.
// ----------------------------------------------------------------------------
// ipv4_endpoint_parser_core
// Parses A.B.C.D:PORT text one character per transfer and returns the status,
// four octets and port after the final character.
// ----------------------------------------------------------------------------
module ipv4_endpoint_parser_core
    import iep_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    output logic        char_stall,
    input  logic [7:0]  char_code,
    input  logic        end_of_text,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  status,
    output logic [7:0]  octet_a,
    output logic [7:0]  octet_b,
    output logic [7:0]  octet_c,
    output logic [7:0]  octet_d,
    output logic [15:0] port_number
);

    logic        s1_valid_reg;
    logic [7:0]  s1_char_reg;
    logic        s1_last_reg;
    logic        s1_advance;
    logic        out_valid_reg;
    iep_result_t out_reg;
    iep_result_t parse_result;

    // a non-final character never waits on the result side
    assign s1_advance = s1_valid_reg && (!s1_last_reg || !out_valid_reg || !result_stall);
    assign char_stall = s1_valid_reg && !s1_advance;

    iep_parse u_parse (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (s1_advance),
        .ch     (s1_char_reg),
        .last   (s1_last_reg),
        .result (parse_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!char_stall)
                s1_valid_reg <= char_valid;
            if (s1_advance && s1_last_reg)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!char_stall && char_valid)
        begin
            s1_char_reg <= char_code;
            s1_last_reg <= end_of_text;
        end
        if (s1_advance && s1_last_reg)
            out_reg <= parse_result;
    end

    assign result_valid = out_valid_reg;
    assign status       = out_reg.status;
    assign octet_a      = out_reg.octet_a;
    assign octet_b      = out_reg.octet_b;
    assign octet_c      = out_reg.octet_c;
    assign octet_d      = out_reg.octet_d;
    assign port_number  = out_reg.port_number;

    a_fault_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status != STATUS_OK |->
            octet_a == 8'd0 && octet_b == 8'd0 && octet_c == 8'd0 &&
            octet_d == 8'd0 && port_number == 16'd0)
        else $error("fields not zero on a fault status");

    a_ok_port: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == STATUS_OK |-> port_number != 16'd0)
        else $error("ok status with port zero");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        char_stall |-> s1_valid_reg && s1_last_reg && out_valid_reg)
        else $error("input stalled without a pending final character");

    a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && s1_last_reg |=> result_valid)
        else $error("final character gave no result");

endmodule
